[rtl/mioc_pkg.sv]
package mioc_pkg;

  // Field widths of the payload.
  localparam int TIME_BITS = 12;
  localparam int PEAK_BITS = 8;

  // One input interval.
  typedef struct packed {
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] departure_time;
    logic                 is_last;
  } item_t;

  // One result of a set.
  typedef struct packed {
    logic [PEAK_BITS-1:0] peak_overlap;
    logic                 overflow;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // an item transfer happens this cycle
    logic init;     // start the pairwise pass
    logic fetch;    // read the arrival of the outer interval
    logic latch;    // capture the outer arrival, restart the inner scan
    logic scan;     // read one inner interval
    logic drain;    // close one outer interval
    logic finish;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_last;  // the offered item closes the set
    logic j_last;     // the inner scan reads its final entry
    logic i_last;     // the outer interval is the final one
    logic out_free;   // the output register can take a result
  } ctrl_status_t;

endpackage

[rtl/mioc_ram.sv]
module mioc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mioc_ctrl.sv]
module mioc_ctrl
  import mioc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      S_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (status.item_last) begin
            cmd.init   = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.j_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (status.i_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

[rtl/mioc_datapath.sv]
module mioc_datapath
  import mioc_pkg::*;
#(
  parameter int MAX_INTERVALS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  item_t        item,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result
);

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [CW-1:0]        count;
  logic                 ovf;
  logic [CW-1:0]        i;
  logic [CW-1:0]        j;
  logic [CW-1:0]        j_d;
  logic                 cmp_valid;
  logic [TIME_BITS-1:0] start;
  logic [CW-1:0]        present;
  logic [CW-1:0]        best;

  logic                 we;
  logic [IW-1:0]        raddr;
  logic [TIME_BITS-1:0] arr_rd;
  logic [TIME_BITS-1:0] dep_rd;
  logic                 hit;
  logic [CW-1:0]        present_sum;
  logic [31:0]          best_w;

  // Interval stores, written in order during the load phase.
  assign we    = cmd.load && (count != MAX_COUNT);
  assign raddr = cmd.fetch ? i[IW-1:0] : j[IW-1:0];

  mioc_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_INTERVALS)
  ) u_arr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[IW-1:0]),
    .wdata (item.arrival_time),
    .raddr (raddr),
    .rdata (arr_rd)
  );

  mioc_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_INTERVALS)
  ) u_dep_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[IW-1:0]),
    .wdata (item.departure_time),
    .raddr (raddr),
    .rdata (dep_rd)
  );

  // An inner interval counts when it started no later and is still present.
  assign hit = cmp_valid && (j_d != i) && (arr_rd <= start) && (dep_rd > start);
  assign present_sum = present + CW'(hit);

  // Fill count and overflow flag of the current set.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.finish) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (count != MAX_COUNT) begin
        count <= count + ONE;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Compare pipeline valid, registered from the scan command alongside the inner read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan;
    end
  end

  // Loop counters and accumulators of the pairwise pass.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      i    <= '0;
      best <= ONE;
    end
    if (cmd.latch) begin
      start   <= arr_rd;
      present <= ONE;
      j       <= '0;
    end else begin
      if (cmd.scan) begin
        j <= j + ONE;
      end
      present <= present_sum;
    end
    j_d <= j;
    if (cmd.drain) begin
      i <= i + ONE;
      if (present_sum > best) begin
        best <= present_sum;
      end
    end
  end

  // Output register, loaded once per set.
  assign best_w = 32'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.peak_overlap <= (best_w > 32'd255) ? 8'd255 : best_w[PEAK_BITS-1:0];
      result.overflow     <= ovf;
    end
  end

  // Status toward the controller.
  assign status.item_last = item.is_last;
  assign status.j_last    = (j == count - ONE);
  assign status.i_last    = (i == count - ONE);
  assign status.out_free  = !result_valid || !result_stall;

`ifndef SYNTHESIS
  // The fill count never passes the store depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("fill count beyond store depth");

  // Overflow can only be flagged once the store is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == MAX_COUNT))
    else $error("overflow flagged with room left");

  // The running overlap never exceeds the number of stored intervals.
  a_present_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.drain) |-> (present <= count))
    else $error("overlap count beyond stored intervals");

  // A finished pass always shows a result in the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("result lost after pass");
`endif

endmodule

[rtl/max_interval_overlap_counter.sv]
// Peak overlap of a set of intervals (minimum number of platforms or chairs).
//
// Input channel (item, item_valid, item_stall): one interval per transfer.
// Items are taken one per cycle while the block is loading. The item with
// is_last set closes the set and starts the pairwise pass; item_stall stays
// high until that pass has placed its result in the output register.
// Intervals beyond MAX_INTERVALS are dropped and flag overflow.
// Output channel (result, result_valid, result_stall): one transfer per set.
// With n stored intervals, the pass after the transfer of the closing item
// takes, for each outer interval in turn, a fetch, a latch, n inner compares
// and a close, one after another since the interval stores each have a
// single read port; a last step then moves the result into the output
// register.
// The output register holds the result while result_stall is high; loading
// of the next set goes on meanwhile, and a next pass waits at its end until
// the register is free.
// Reset empties the set, clears the overflow flag and drops a pending result;
// store contents are not cleared and need no clearing pass.
module max_interval_overlap_counter
  import mioc_pkg::*;
#(
  parameter int MAX_INTERVALS = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer of the load phase and the pairwise pass.
  mioc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Stores, counters, comparator and output register.
  mioc_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[test/max_interval_overlap_counter_test.sv]
`timescale 1ns / 1ps

module max_interval_overlap_counter_test;
  import mioc_pkg::*;

  localparam int SET_CAPACITY    = 128;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_ITEMS    = 1900;

  // How the times of a random set are drawn.
  typedef enum {
    TIMES_CLOCK,
    TIMES_FULL,
    TIMES_CLUSTER,
    TIMES_SPREAD
  } time_style_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Stimulus waiting to be offered, and results owed by the block.
  item_t   intervals_to_send[$];
  result_t pending_peaks[$];

  // Our own copy of the interval stores for the set being loaded.
  logic [TIME_BITS-1:0] set_arrival[SET_CAPACITY];
  logic [TIME_BITS-1:0] set_departure[SET_CAPACITY];
  int   set_fill = 0;
  logic set_dropped = 1'b0;

  int   fail_count = 0;
  int   sets_checked = 0;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   wind_down = 1'b0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 20;

  max_interval_overlap_counter #(
    .MAX_INTERVALS(SET_CAPACITY)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Peak overlap of the stored set: for every interval, count the others
  // that started no later and are still present at its start.
  function automatic logic [PEAK_BITS-1:0] peak_overlap_of_set();
    int best;
    int present;
    best = 1;
    for (int i = 0; i < set_fill; i++) begin
      present = 1;
      for (int j = 0; j < set_fill; j++) begin
        if (j != i && set_arrival[j] <= set_arrival[i] &&
            set_departure[j] > set_arrival[i]) begin
          present++;
        end
      end
      if (present > best) begin
        best = present;
      end
    end
    return (best > 255) ? 8'd255 : PEAK_BITS'(best);
  endfunction

  function automatic int idle_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] clock_time();
    return TIME_BITS'($urandom_range(0, 23) * 100 + $urandom_range(0, 59));
  endfunction

  task automatic add_interval(int arr, int dep, bit last);
    item_t it;
    it.arrival_time   = TIME_BITS'(arr);
    it.departure_time = TIME_BITS'(dep);
    it.is_last        = last;
    intervals_to_send.push_back(it);
  endtask

  // Queue one whole set; the final interval carries the last flag.
  task automatic add_set(int count, time_style_t style);
    item_t it;
    int base;
    base = $urandom_range(0, 2200);
    for (int k = 0; k < count; k++) begin
      case (style)
        TIMES_FULL: begin
          it.arrival_time   = TIME_BITS'($urandom);
          it.departure_time = TIME_BITS'($urandom);
        end
        TIMES_CLUSTER: begin
          it.arrival_time   = TIME_BITS'(base + $urandom_range(0, 40));
          it.departure_time = TIME_BITS'(int'(it.arrival_time) + $urandom_range(0, 90));
        end
        TIMES_CLOCK: begin
          it.arrival_time = clock_time();
          if ($urandom_range(0, 1) == 0) begin
            it.departure_time = clock_time();
          end else begin
            it.departure_time = TIME_BITS'(int'(it.arrival_time) + $urandom_range(1, 300));
          end
        end
        default: begin
          it.arrival_time   = TIME_BITS'($urandom_range(0, 2359));
          it.departure_time = TIME_BITS'($urandom_range(0, 2359));
        end
      endcase
      it.is_last = (k == count - 1);
      intervals_to_send.push_back(it);
    end
  endtask

  // Sender: offers queued intervals, with random idle bursts until fewer than 300 remain queued.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else if (!item_valid || !item_stall) begin
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (intervals_to_send.size() == 0) begin
        item_valid <= 1'b0;
      end else if (!wind_down && $urandom_range(0, 99) < send_idle_pct) begin
        item_valid <= 1'b0;
        send_gap   <= $urandom_range(0, 10);
      end else begin
        item       <= intervals_to_send.pop_front();
        item_valid <= 1'b1;
        items_sent <= items_sent + 1;
        wind_down  <= (intervals_to_send.size() < 300);
        if (items_sent % 128 == 127) begin
          send_idle_pct <= idle_level();
          recv_idle_pct <= idle_level();
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so that the block
  // backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && sets_checked >= 20) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      hold_done    <= 1'b1;
    end else if (recv_gap != 0) begin
      result_stall <= 1'b1;
      recv_gap     <= recv_gap - 1;
    end else if (!wind_down && $urandom_range(0, 99) < recv_idle_pct) begin
      result_stall <= 1'b1;
      recv_gap     <= $urandom_range(0, 10);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Monitor: checks each result transfer, then predicts from each item transfer.
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_peaks.size() == 0) begin
          report_mismatch($sformatf("result peak %0d overflow %0b with no set pending",
                                    result.peak_overlap, result.overflow));
        end else begin
          want = pending_peaks.pop_front();
          if (result.peak_overlap !== want.peak_overlap) begin
            report_mismatch($sformatf("set %0d peak_overlap got %0d, expected %0d",
                                      sets_checked, result.peak_overlap,
                                      want.peak_overlap));
          end
          if (result.overflow !== want.overflow) begin
            report_mismatch($sformatf("set %0d overflow got %0b, expected %0b",
                                      sets_checked, result.overflow, want.overflow));
          end
        end
        sets_checked <= sets_checked + 1;
      end

      if (item_valid && !item_stall) begin
        if (set_fill < SET_CAPACITY) begin
          set_arrival[set_fill]   = item.arrival_time;
          set_departure[set_fill] = item.departure_time;
          set_fill++;
        end else begin
          set_dropped = 1'b1;
        end
        if (item.is_last) begin
          want.peak_overlap = peak_overlap_of_set();
          want.overflow     = set_dropped;
          pending_peaks.push_back(want);
          set_fill    = 0;
          set_dropped = 1'b0;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int queued;
    int set_index;

    // A lone interval at the bottom and at the top of the field range.
    add_interval(0, 0, 1'b1);
    add_interval(4095, 4095, 1'b1);
    // Tied arrivals all count against each other.
    add_interval(100, 200, 1'b0);
    add_interval(100, 200, 1'b0);
    add_interval(100, 200, 1'b1);
    // A departure equal to a later arrival does not overlap it.
    add_interval(900, 1000, 1'b0);
    add_interval(1000, 1100, 1'b1);
    add_interval(1000, 1100, 1'b0);
    add_interval(900, 1000, 1'b1);
    // Departures before arrivals, and one interval spanning the whole day.
    add_interval(2000, 100, 1'b0);
    add_interval(2359, 0, 1'b0);
    add_interval(2100, 2359, 1'b0);
    add_interval(0, 2359, 1'b0);
    add_interval(1200, 1300, 1'b0);
    add_interval(1250, 4095, 1'b1);
    // Alternating, all-ones and all-zeros bit patterns in both time fields.
    add_interval(12'hAAA, 12'h555, 1'b0);
    add_interval(12'h555, 12'hAAA, 1'b0);
    add_interval(12'hFFF, 12'h000, 1'b0);
    add_interval(12'h000, 12'hFFF, 1'b1);

    // Random sets: mostly small, a few that fill or overflow the stores.
    queued    = 0;
    set_index = 0;
    while (queued < RANDOM_ITEMS) begin
      int count;
      case (set_index)
        10:      count = SET_CAPACITY;
        40:      count = SET_CAPACITY + 1;
        70:      count = SET_CAPACITY + 6;
        100:     count = SET_CAPACITY + 32;
        default: count = $urandom_range(1, 16);
      endcase
      add_set(count, time_style_t'($urandom_range(0, 3)));
      queued += count;
      set_index++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (intervals_to_send.size() != 0 || item_valid) @(posedge clk);
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mioc_pkg.sv
rtl/mioc_ram.sv
rtl/mioc_ctrl.sv
rtl/mioc_datapath.sv
rtl/max_interval_overlap_counter.sv
test/max_interval_overlap_counter_test.sv
